// ===== rtl/core/tarm_pkg.sv =====
// shared types, constants and register indexes of the axis reduce-mean block
`timescale 1ns / 1ps
`default_nettype none

package tarm_pkg;

    // fixed field and datapath widths
    localparam int NDIM       = 4;
    localparam int DIM_W      = 8;
    localparam int DIM_IDX_W  = 2;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 48;
    localparam int RED_W      = 32;
    localparam int OIDX_W     = 6;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // parameter defaults
    localparam int DEF_OUT_DEPTH = 64;
    localparam int DEF_MAX_RANK  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXES_MASK  = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_RD,
        S_WR,
        S_DRD,
        S_DLOAD,
        S_DWAIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic                 accept;
        logic                 dim_step;
        logic [DIM_IDX_W-1:0] dim;
        logic                 acc_rd;
        logic                 acc_wr;
        logic                 drain_rd;
        logic                 div_load;
        logic                 emit;
        logic                 k_inc;
        logic                 clr_valid;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic wrapped;
        logic div_busy;
        logic last_k;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/tensor_axis_reduce_mean.sv =====
// top level of the streaming axis reduce-mean block
`timescale 1ns / 1ps
`default_nettype none

// Streaming mean over selected axes of a rank-4 tensor of signed Q8.8 samples.
// Input: one sample transaction at each edge with start high and busy low,
// elements in row-major order. Each sample is added, with saturation, into the
// accumulator of its kept output position; each accepted sample passes through
// the idle state, four index steps, a memory read and a memory write before
// the next sample can be taken, set by the one-dimension-per-cycle index
// multiplier and the single-port accumulator memory.
// After the final element of a tensor the block drains the kept positions (at most
// OUT_DEPTH) in order: each result is one o_mean_valid cycle, preceded by a drain
// read, a divider load and 48 steps of the bit-serial divider.
// Results cannot be held off: the receiver must take each strobe as it comes.
// Accumulators are cleared at once through valid bits after the last result.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
// and belong only in idle time. Synchronous reset restores all sizes to 1,
// the axes mask to all reduced, the position counters and accumulators to zero.

module tensor_axis_reduce_mean #(
    parameter int OUT_DEPTH = tarm_pkg::DEF_OUT_DEPTH,
    parameter int MAX_RANK  = tarm_pkg::DEF_MAX_RANK
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tarm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tarm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic signed [tarm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                      o_mean_valid,
    output logic signed [tarm_pkg::SAMPLE_W-1:0]      o_mean,
    output logic [tarm_pkg::OIDX_W-1:0]               o_out_index,
    output logic                                      o_last,
    output logic                                      o_fault
);

    tarm_pkg::t_cmd    cmd;
    tarm_pkg::t_status status;

    // sequencing
    tarm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // arithmetic and storage
    tarm_dp #(
        .OUT_DEPTH (OUT_DEPTH),
        .MAX_RANK  (MAX_RANK)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_mean_valid (o_mean_valid),
        .o_mean       (o_mean),
        .o_out_index  (o_out_index),
        .o_last       (o_last),
        .o_fault      (o_fault)
    );

`ifndef SYNTHESIS
    // results are spaced by the divider, never back to back
    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mean_valid |=> !o_mean_valid)
        else $error("result strobes in consecutive cycles");

    // the final result of a tensor leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mean_valid && o_last) |-> !busy)
        else $error("busy still high on final result");

    // an accepted sample always starts the sequence
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("sample accepted without going busy");

    // the drain only emits while the controller is in its drain states
    a_emit_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (busy && !status.div_busy))
        else $error("emit outside drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tarm_div.sv =====
// iterative restoring divider: signed accumulator by unsigned divisor, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module tarm_div #(
    parameter int NUM_W = tarm_pkg::ACC_W,
    parameter int DEN_W = tarm_pkg::RED_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quo,
    output logic                  o_neg
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             ge;
    logic [NUM_W-1:0] num_mag;

    // magnitude of the dividend
    assign num_mag = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;

    // one quotient bit per step
    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign ge     = ~diff[DEN_W+1];

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CW'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q   <= num_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign o_neg  = r_neg;

endmodule

`default_nettype wire

// ===== rtl/core/tarm_ctrl.sv =====
// controller state machine: sample accumulate sequence and result drain sequence
`timescale 1ns / 1ps
`default_nettype none

module tarm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tarm_pkg::t_status i_status,
    output tarm_pkg::t_cmd         o_cmd,
    output logic                   o_busy
);

    tarm_pkg::t_state                   r_state;
    tarm_pkg::t_state                   n_state;
    logic [tarm_pkg::DIM_IDX_W-1:0]     r_dim;
    logic [tarm_pkg::DIM_IDX_W-1:0]     n_dim;
    logic                               dim_done;

    assign dim_done = (r_dim == tarm_pkg::DIM_IDX_W'(tarm_pkg::NDIM - 1));

    // state and dimension step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tarm_pkg::S_IDLE;
            r_dim   <= '0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
        end
    end

    // dimension step counter
    always_comb begin
        n_dim = (r_state == tarm_pkg::S_IDX) ? r_dim + tarm_pkg::DIM_IDX_W'(1) : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tarm_pkg::S_IDLE: begin
                if (i_start) n_state = tarm_pkg::S_IDX;
            end
            tarm_pkg::S_IDX: begin
                if (dim_done) n_state = tarm_pkg::S_RD;
            end
            tarm_pkg::S_RD: begin
                n_state = tarm_pkg::S_WR;
            end
            tarm_pkg::S_WR: begin
                n_state = i_status.wrapped ? tarm_pkg::S_DRD : tarm_pkg::S_IDLE;
            end
            tarm_pkg::S_DRD: begin
                n_state = tarm_pkg::S_DLOAD;
            end
            tarm_pkg::S_DLOAD: begin
                n_state = tarm_pkg::S_DWAIT;
            end
            tarm_pkg::S_DWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = i_status.last_k ? tarm_pkg::S_IDLE : tarm_pkg::S_DRD;
                end
            end
            default: n_state = tarm_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd     = '0;
        o_cmd.dim = r_dim;
        unique case (r_state)
            tarm_pkg::S_IDLE:  o_cmd.accept   = i_start;
            tarm_pkg::S_IDX:   o_cmd.dim_step = 1'b1;
            tarm_pkg::S_RD:    o_cmd.acc_rd   = 1'b1;
            tarm_pkg::S_WR:    o_cmd.acc_wr   = 1'b1;
            tarm_pkg::S_DRD:   o_cmd.drain_rd = 1'b1;
            tarm_pkg::S_DLOAD: o_cmd.div_load = 1'b1;
            tarm_pkg::S_DWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.clr_valid = i_status.last_k;
                    o_cmd.k_inc     = ~i_status.last_k;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != tarm_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/tarm_dp.sv =====
// datapath: config registers, position counters, index math, accumulator memory, divide
`timescale 1ns / 1ps
`default_nettype none

module tarm_dp #(
    parameter int OUT_DEPTH = tarm_pkg::DEF_OUT_DEPTH,
    parameter int MAX_RANK  = tarm_pkg::DEF_MAX_RANK
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tarm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tarm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic signed [tarm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire tarm_pkg::t_cmd                      i_cmd,
    output tarm_pkg::t_status                        o_status,
    output logic                                     o_mean_valid,
    output logic signed [tarm_pkg::SAMPLE_W-1:0]     o_mean,
    output logic [tarm_pkg::OIDX_W-1:0]              o_out_index,
    output logic                                     o_last,
    output logic                                     o_fault
);

    localparam int NDIM  = tarm_pkg::NDIM;
    localparam int DIM_W = tarm_pkg::DIM_W;
    localparam int ACC_W = tarm_pkg::ACC_W;
    localparam int RED_W = tarm_pkg::RED_W;
    localparam int SW    = tarm_pkg::SAMPLE_W;
    localparam int AW    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int IW    = $clog2(OUT_DEPTH + 1);
    localparam int KW    = $clog2(OUT_DEPTH + 2);
    localparam int PW    = IW + DIM_W + 1;
    localparam int QW    = KW + DIM_W;
    localparam int RW    = RED_W + DIM_W;

    // configuration registers
    logic [DIM_W-1:0]            r_dim_size [NDIM];
    logic [tarm_pkg::MASK_W-1:0] r_axes_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NDIM; d++) r_dim_size[d] <= DIM_W'(1);
            r_axes_mask <= '1;
        end else if (i_cfg_we) begin
            for (int d = 0; d < NDIM; d++) begin
                if (d < MAX_RANK &&
                    i_cfg_index == tarm_pkg::CFG_DIM_SIZE_0 + tarm_pkg::CFG_IDX_W'(d)) begin
                    r_dim_size[d] <= i_cfg_data[DIM_W-1:0];
                end
            end
            if (i_cfg_index == tarm_pkg::CFG_AXES_MASK) begin
                r_axes_mask <= i_cfg_data[tarm_pkg::MASK_W-1:0];
            end
        end
    end

    // effective sizes: zero acts as one, dimensions past the rank are one
    logic [DIM_W-1:0] eff [NDIM];

    always_comb begin
        for (int d = 0; d < NDIM; d++) begin
            eff[d] = (d < MAX_RANK && r_dim_size[d] != '0) ? r_dim_size[d] : DIM_W'(1);
        end
    end

    // element position counters, outermost first
    logic [DIM_W-1:0] r_pos [NDIM];
    logic [DIM_W-1:0] n_pos [NDIM];
    logic             wrapped;

    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int d = NDIM - 1; d >= 0; d--) begin
            n_pos[d] = r_pos[d];
            if (carry) begin
                if ({1'b0, r_pos[d]} + (DIM_W + 1)'(1) >= {1'b0, eff[d]}) begin
                    n_pos[d] = '0;
                end else begin
                    n_pos[d] = r_pos[d] + DIM_W'(1);
                    carry    = 1'b0;
                end
            end
        end
        wrapped = carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NDIM; d++) r_pos[d] <= '0;
        end else if (i_cmd.acc_wr) begin
            for (int d = 0; d < NDIM; d++) r_pos[d] <= n_pos[d];
        end
    end

    // output index, kept count and reduced count, one dimension per step
    logic signed [SW-1:0] r_sample;
    logic [IW-1:0]        r_idx;
    logic [KW-1:0]        r_kept;
    logic [RED_W-1:0]     r_red;

    logic [DIM_W-1:0] step_size;
    logic [DIM_W-1:0] step_pos;
    logic [PW-1:0]    idx_prod;
    logic [QW-1:0]    kept_prod;
    logic [RW-1:0]    red_prod;

    assign step_size = eff[i_cmd.dim];
    assign step_pos  = r_pos[i_cmd.dim];
    assign idx_prod  = PW'(r_idx) * PW'(step_size) + PW'(step_pos);
    assign kept_prod = QW'(r_kept) * QW'(step_size);
    assign red_prod  = RW'(r_red) * RW'(step_size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_idx    <= '0;
            r_kept   <= KW'(1);
            r_red    <= RED_W'(1);
        end else if (i_cmd.dim_step) begin
            if (r_axes_mask[i_cmd.dim]) begin
                r_red <= red_prod[RED_W-1:0];
            end else begin
                r_idx  <= (idx_prod >= PW'(OUT_DEPTH)) ? IW'(OUT_DEPTH) : idx_prod[IW-1:0];
                r_kept <= (kept_prod > QW'(OUT_DEPTH)) ? KW'(OUT_DEPTH + 1)
                                                       : kept_prod[KW-1:0];
            end
        end
    end

    // drain position counter
    logic [AW-1:0] r_k;
    logic [KW-1:0] drain_lim;
    logic          last_k;
    logic          over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.acc_wr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + AW'(1);
        end
    end

    assign over      = (r_kept > KW'(OUT_DEPTH));
    assign drain_lim = over ? KW'(OUT_DEPTH) : r_kept;
    assign last_k    = (KW'(r_k) + KW'(1) == drain_lim);

    // accumulator memory with per-entry valid bits
    logic [ACC_W-1:0]     r_acc_mem [OUT_DEPTH];
    logic [OUT_DEPTH-1:0] r_acc_vld;
    logic [ACC_W-1:0]     r_rd_data;
    logic                 r_rd_vld;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 in_range;
    logic [ACC_W-1:0]     sum_sat;

    assign in_range = (r_idx != IW'(OUT_DEPTH));
    assign wr_addr  = r_idx[AW-1:0];
    assign rd_addr  = i_cmd.drain_rd ? r_k : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_rd || i_cmd.drain_rd) begin
            r_rd_data <= r_acc_mem[rd_addr];
            r_rd_vld  <= r_acc_vld[rd_addr];
        end
        if (i_cmd.acc_wr && in_range) begin
            r_acc_mem[wr_addr] <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (i_cmd.clr_valid) begin
            r_acc_vld <= '0;
        end else if (i_cmd.acc_wr && in_range) begin
            r_acc_vld[wr_addr] <= 1'b1;
        end
    end

    // saturating accumulate
    logic [ACC_W-1:0] acc_cur;
    logic [ACC_W:0]   sum_ext;

    assign acc_cur = r_rd_vld ? r_rd_data : '0;
    assign sum_ext = {acc_cur[ACC_W-1], acc_cur}
                   + {{(ACC_W + 1 - SW){r_sample[SW-1]}}, r_sample};

    always_comb begin
        if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
            sum_sat = sum_ext[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_ext[ACC_W-1:0];
        end
    end

    // sum divided by the reduced element count
    logic             div_busy;
    logic [ACC_W-1:0] div_quo;
    logic             div_neg;

    tarm_div #(
        .NUM_W (ACC_W),
        .DEN_W (RED_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.div_load),
        .i_num   (acc_cur),
        .i_den   (r_red),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_neg   (div_neg)
    );

    // clamp the quotient to the sample range
    logic          quo_big;
    logic [SW-1:0] mean_sat;

    assign quo_big = |div_quo[ACC_W-1:SW-1];

    always_comb begin
        if (div_neg) begin
            mean_sat = quo_big ? {1'b1, {(SW - 1){1'b0}}} : (~div_quo[SW-1:0] + SW'(1));
        end else begin
            mean_sat = quo_big ? {1'b0, {(SW - 1){1'b1}}} : div_quo[SW-1:0];
        end
    end

    // result transaction registers
    logic                 r_out_valid;
    logic signed [SW-1:0] r_mean;
    logic [tarm_pkg::OIDX_W-1:0] r_out_index;
    logic                 r_last;
    logic                 r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mean      <= mean_sat;
            r_out_index <= tarm_pkg::OIDX_W'(r_k);
            r_last      <= last_k;
            r_fault     <= over;
        end
    end

    assign o_mean_valid      = r_out_valid;
    assign o_mean            = r_mean;
    assign o_out_index       = r_out_index;
    assign o_last            = r_last;
    assign o_fault           = r_fault;

    assign o_status.wrapped  = wrapped;
    assign o_status.div_busy = div_busy;
    assign o_status.last_k   = last_k;

endmodule

`default_nettype wire
